// ===== rtl/rmgq_pkg.sv =====
// role matched group queue: shared types, codes and default sizes
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package rmgq_pkg;

	localparam int DEF_DEPTH = 64;

	localparam int ID_W      = 16;
	localparam int ROLE_W    = 2;
	localparam int REQ_W     = 2;
	localparam int STAT_W    = 2;
	localparam int COUNT_W   = 7;
	localparam int NUM_ROLES = 3;

	localparam logic [REQ_W-1:0] REQ_PUSH      = 2'd0;
	localparam logic [REQ_W-1:0] REQ_POP_ROLE  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_POP_GROUP = 2'd2;
	localparam logic [REQ_W-1:0] REQ_QUERY     = 2'd3;

	localparam logic [STAT_W-1:0] STAT_DONE     = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL     = 2'd1;
	localparam logic [STAT_W-1:0] STAT_NO_MATCH = 2'd2;

	localparam logic [ROLE_W-1:0] ROLE_DEFENDER = 2'd0;
	localparam logic [ROLE_W-1:0] ROLE_HUNTER   = 2'd1;
	localparam logic [ROLE_W-1:0] ROLE_BARD     = 2'd2;

	typedef struct packed {
		logic [ROLE_W-1:0] role;
		logic [ID_W-1:0]   id;
	} entry_t;

	typedef struct packed {
		logic [STAT_W-1:0]               status;
		logic [COUNT_W-1:0]              entry_count;
		logic [NUM_ROLES-1:0]            found;
		logic [NUM_ROLES-1:0][ID_W-1:0]  ids;
	} result_t;

	// one-hot role select, all zero for the unused role code
	function automatic logic [NUM_ROLES-1:0] role_sel(input logic [ROLE_W-1:0] r);
		logic [NUM_ROLES-1:0] s;
		s = '0;
		unique case (r)
			ROLE_DEFENDER: s = 3'b001;
			ROLE_HUNTER:   s = 3'b010;
			ROLE_BARD:     s = 3'b100;
			default:       s = '0;
		endcase
		return s;
	endfunction

endpackage

// ===== rtl/rmgq_store.sv =====
// entry memory: one write port, one read port with registered read data
// depends on rmgq_pkg for the entry type
`timescale 1ns / 1ps

module rmgq_store #(
	parameter int DEPTH = rmgq_pkg::DEF_DEPTH,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                 clk,
	input  logic                 wr_en,
	input  logic [AW-1:0]        wr_addr,
	input  rmgq_pkg::entry_t     wr_data,
	input  logic                 rd_en,
	input  logic [AW-1:0]        rd_addr,
	output rmgq_pkg::entry_t     rd_data
);

	rmgq_pkg::entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== rtl/rmgq_engine.sv =====
// request sequencer: one compaction pass over the entry memory per request,
// dropping removed entries, appending pushes and finding the oldest of each role
// depends on rmgq_pkg and rmgq_store
`timescale 1ns / 1ps

module rmgq_engine #(
	parameter int QUEUE_DEPTH = rmgq_pkg::DEF_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [rmgq_pkg::REQ_W-1:0]    req_type,
	input  logic [rmgq_pkg::ID_W-1:0]     player_id,
	input  logic [rmgq_pkg::ROLE_W-1:0]   role,
	output logic                          idle,
	output logic                          res_valid,
	input  logic                          res_take,
	output rmgq_pkg::result_t             res
);

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int NR = rmgq_pkg::NUM_ROLES;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	logic [1:0]                      state_q;
	logic [CW-1:0]                   held_q, n_q, rd_q, w_q;
	logic [NR-1:0][CW-1:0]           cnt_q;
	logic [NR-1:0]                   rmv_q, found_q, psel_q;
	logic                            app_q, vld_s1;
	logic [rmgq_pkg::ID_W-1:0]       id_q;
	logic [rmgq_pkg::ROLE_W-1:0]     role_q;
	logic [rmgq_pkg::STAT_W-1:0]     status_q;
	logic [NR-1:0][rmgq_pkg::ID_W-1:0] fid_q;

	// request decode
	logic [NR-1:0]                   has, sel_in, rmv_n;
	logic                            app_n;
	logic [rmgq_pkg::STAT_W-1:0]     status_n;

	// pass datapath
	rmgq_pkg::entry_t                rd_data, wr_data;
	logic                            rd_en, wr_en, drop, keep, pass_end, do_app;
	logic [NR-1:0]                   rsel, new_f, app_f;

	always_comb begin
		for (int k = 0; k < NR; k++) begin
			has[k] = (cnt_q[k] != '0);
		end
		sel_in   = rmgq_pkg::role_sel(role);
		rmv_n    = '0;
		app_n    = 1'b0;
		status_n = rmgq_pkg::STAT_DONE;
		unique case (req_type)
			rmgq_pkg::REQ_PUSH: begin
				if (held_q == CW'(QUEUE_DEPTH)) begin
					status_n = rmgq_pkg::STAT_FULL;
				end else begin
					app_n = 1'b1;
				end
			end
			rmgq_pkg::REQ_POP_ROLE: begin
				rmv_n = sel_in & has;
				if (rmv_n == '0) begin
					status_n = rmgq_pkg::STAT_NO_MATCH;
				end
			end
			rmgq_pkg::REQ_POP_GROUP: begin
				if (&has) begin
					rmv_n = '1;
				end else begin
					status_n = rmgq_pkg::STAT_NO_MATCH;
				end
			end
			rmgq_pkg::REQ_QUERY: begin
				status_n = rmgq_pkg::STAT_DONE;
			end
			default: begin
				status_n = rmgq_pkg::STAT_DONE;
			end
		endcase
	end

	assign rd_en    = (state_q == ST_RUN) && (rd_q != n_q);
	assign rsel     = rmgq_pkg::role_sel(rd_data.role);
	assign drop     = vld_s1 && ((rsel & rmv_q) != '0);
	assign keep     = vld_s1 && !drop;
	assign new_f    = keep ? (rsel & ~found_q) : '0;
	assign pass_end = (state_q == ST_RUN) && (rd_q == n_q) && !vld_s1;
	assign do_app   = pass_end && app_q;
	assign app_f    = do_app ? (psel_q & ~found_q) : '0;
	assign wr_en    = keep || do_app;
	assign wr_data  = keep ? rd_data : rmgq_pkg::entry_t'{role: role_q, id: id_q};

	rmgq_store #(
		.DEPTH (QUEUE_DEPTH),
		.AW    (AW)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (w_q[AW-1:0]),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_q[AW-1:0]),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			held_q  <= '0;
			n_q     <= '0;
			rd_q    <= '0;
			w_q     <= '0;
			cnt_q   <= '0;
			rmv_q   <= '0;
			found_q <= '0;
			psel_q  <= '0;
			app_q   <= 1'b0;
			vld_s1  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						for (int k = 0; k < NR; k++) begin
							cnt_q[k] <= cnt_q[k] + CW'(app_n && sel_in[k]) - CW'(rmv_n[k]);
						end
						held_q  <= held_q + CW'(app_n) - CW'(rmv_n[0]) - CW'(rmv_n[1])
							- CW'(rmv_n[2]);
						n_q     <= held_q;
						rd_q    <= '0;
						w_q     <= '0;
						rmv_q   <= rmv_n;
						found_q <= '0;
						psel_q  <= sel_in;
						app_q   <= app_n;
						vld_s1  <= 1'b0;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					vld_s1 <= rd_en;
					if (rd_en) begin
						rd_q <= rd_q + CW'(1);
					end
					if (drop) begin
						rmv_q <= rmv_q & ~rsel;
					end
					if (keep) begin
						w_q <= w_q + CW'(1);
					end
					found_q <= found_q | new_f | app_f;
					if (pass_end) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (res_take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			id_q     <= player_id;
			role_q   <= role;
			status_q <= status_n;
			fid_q    <= '0;
		end else begin
			for (int k = 0; k < NR; k++) begin
				if (new_f[k]) begin
					fid_q[k] <= rd_data.id;
				end else if (app_f[k]) begin
					fid_q[k] <= id_q;
				end
			end
		end
	end

	assign idle            = (state_q == ST_IDLE);
	assign res_valid       = (state_q == ST_FIN);
	assign res.status      = status_q;
	assign res.entry_count = rmgq_pkg::COUNT_W'(held_q);
	assign res.found       = found_q;
	assign res.ids         = fid_q;

endmodule

// ===== rtl/role_matched_group_queue.sv =====
// role matched group queue top level: stream ports and result word register
// depends on rmgq_pkg, rmgq_engine and rmgq_store
//
// channel  dir  tdata (low bit up)                              tuser
// s_axis   in   player_id[15:0] role[17:16], zero to 24 bits     req_type[1:0]
// m_axis   out  status[1:0] entry_count[8:2] defender_found[9]   -
//               defender_id[25:10] hunter_found[26] hunter_id[42:27]
//               bard_found[43] bard_id[59:44] group_ready[60], zero to 64 bits
//
// with n entries held at acceptance the sequencer reads each held entry once, waits
// for the registered read data, appends a push and hands the result word over to
// the output register; the hand-over waits while a word there is not yet taken.
// the next request is accepted only after the hand-over; the single memory read
// port reads one entry at a time, so the pass grows with n. s_axis_tready is high
// when the sequencer is idle, also while a result word waits in the output register.
// arst_n clears the queue to empty; memory contents are not cleared.
`timescale 1ns / 1ps

module role_matched_group_queue #(
	parameter int QUEUE_DEPTH = rmgq_pkg::DEF_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // player_id, role
	input  logic [1:0]  s_axis_tuser,  // req_type
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata   // status, entry_count, defender_found, defender_id,
	                                   // hunter_found, hunter_id, bard_found, bard_id,
	                                   // group_ready
);

	logic              eng_idle, res_valid, res_take, start;
	rmgq_pkg::result_t res, res_q;
	logic              out_valid_q;

	assign start    = s_axis_tvalid && eng_idle;
	assign res_take = res_valid && (!out_valid_q || m_axis_tready);

	rmgq_engine #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.req_type  (s_axis_tuser),
		.player_id (s_axis_tdata[15:0]),
		.role      (s_axis_tdata[17:16]),
		.idle      (eng_idle),
		.res_valid (res_valid),
		.res_take  (res_take),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			res_q <= res;
		end
	end

	assign s_axis_tready = eng_idle;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'b000, &res_q.found,
		res_q.ids[2], res_q.found[2],
		res_q.ids[1], res_q.found[1],
		res_q.ids[0], res_q.found[0],
		res_q.entry_count, res_q.status};

endmodule
